// ===== hw/rtl/pfc_pkg.sv =====
package pfc_pkg;

  localparam int unsigned MASK_W      = 15;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned PARAM_COUNT = 15;

  localparam logic [7:0] PREAMBLE_BYTE = 8'hAA;

  typedef enum logic [2:0] {
    SEL_PRE,
    SEL_CNT,
    SEL_CODE,
    SEL_VAL,
    SEL_CRC
  } byte_sel_t;

  typedef struct packed {
    logic       emit;
    logic       crc_clr;
    byte_sel_t  sel;
    logic [1:0] lane;
    logic [7:0] cnt_byte;
    logic       frame_end;
    logic       run_last;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic hit;
    logic full;
    logic any_sent;
  } dp_stat_t;

  // reflected crc-32, one nibble per lookup
  function automatic logic [31:0] nib_entry(input logic [3:0] n);
    logic [31:0] r;
    case (n)
      4'h0: r = 32'h00000000;
      4'h1: r = 32'h1DB71064;
      4'h2: r = 32'h3B6E20C8;
      4'h3: r = 32'h26D930AC;
      4'h4: r = 32'h76DC4190;
      4'h5: r = 32'h6B6B51F4;
      4'h6: r = 32'h4DB26158;
      4'h7: r = 32'h5005713C;
      4'h8: r = 32'hEDB88320;
      4'h9: r = 32'hF00F9344;
      4'hA: r = 32'hD6D6A3E8;
      4'hB: r = 32'hCB61B38C;
      4'hC: r = 32'h9B64C2B0;
      4'hD: r = 32'h86D3D2D4;
      4'hE: r = 32'hA00AE278;
      default: r = 32'hBDBDF21C;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] t;
    t = c ^ {24'd0, b};
    t = (t >> 4) ^ nib_entry(t[3:0]);
    t = (t >> 4) ^ nib_entry(t[3:0]);
    return t;
  endfunction

endpackage

// ===== hw/rtl/pfc_if.sv =====
interface pfc_in_if;
  logic                          valid;
  logic                          ready;
  logic [pfc_pkg::IDX_W-1:0]     param_index;
  logic [pfc_pkg::VAL_W-1:0]     param_value;
  logic                          last_param;

  modport source (output valid, param_index, param_value, last_param, input ready);
  modport sink   (input valid, param_index, param_value, last_param, output ready);
endinterface

interface pfc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic       run_last;

  modport source (output valid, out_byte, frame_end, run_last, input ready);
  modport sink   (input valid, out_byte, frame_end, run_last, output ready);
endinterface

interface pfc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [pfc_pkg::MASK_W-1:0] param_mask;

  modport source (output valid, param_mask, input ready);
  modport sink   (input valid, param_mask, output ready);
endinterface

// ===== hw/rtl/pfc_ctrl.sv =====
module pfc_ctrl #(
  parameter int unsigned ENTRIES_PER_FRAME = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_accept,
  input  logic                     in_last_param,
  input  pfc_pkg::dp_stat_t        stat,
  input  logic [((ENTRIES_PER_FRAME > 1) ? $clog2(ENTRIES_PER_FRAME) : 1)-1:0] fill_count,
  output logic                     in_ready,
  output pfc_pkg::dp_cmd_t         cmd,
  output logic [((ENTRIES_PER_FRAME > 1) ? $clog2(ENTRIES_PER_FRAME) : 1)-1:0] ent_idx
);

  localparam int unsigned IW = (ENTRIES_PER_FRAME > 1) ? $clog2(ENTRIES_PER_FRAME) : 1;
  localparam int unsigned CW = $clog2(ENTRIES_PER_FRAME + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE,
    S_CNT,
    S_CODE,
    S_VAL,
    S_CRC
  } state_t;

  state_t        state_r, state_nxt;
  logic [1:0]    lane_r, lane_nxt;
  logic [CW-1:0] ent_r, ent_nxt;
  logic [CW-1:0] fcnt_r, fcnt_nxt;
  logic          close_pend_r, close_pend_nxt;
  logic          final_r, final_nxt;
  logic          close_req;

  assign close_req = in_last_param && (stat.any_sent || stat.hit);
  assign in_ready  = (state_r == S_IDLE);
  assign ent_idx   = ent_r[IW-1:0];

  always_comb begin
    state_nxt      = state_r;
    lane_nxt       = lane_r;
    ent_nxt        = ent_r;
    fcnt_nxt       = fcnt_r;
    close_pend_nxt = close_pend_r;
    final_nxt      = final_r;
    cmd            = '0;
    cmd.sel        = pfc_pkg::SEL_PRE;
    cmd.lane       = lane_r;
    cmd.cnt_byte   = 8'(fcnt_r);
    unique case (state_r)
      S_IDLE: begin
        lane_nxt = 2'd0;
        if (in_accept) begin
          if (stat.full) begin
            state_nxt      = S_PRE;
            fcnt_nxt       = CW'(ENTRIES_PER_FRAME);
            close_pend_nxt = close_req;
            final_nxt      = !close_req;
          end else if (close_req) begin
            state_nxt      = S_PRE;
            fcnt_nxt       = CW'(fill_count) + CW'(stat.hit);
            close_pend_nxt = 1'b0;
            final_nxt      = 1'b1;
          end
        end
      end
      S_PRE: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.sel     = pfc_pkg::SEL_PRE;
          cmd.crc_clr = (lane_r == 2'd0);
          lane_nxt    = lane_r + 2'd1;
          if (lane_r == 2'd3) begin
            state_nxt = S_CNT;
          end
        end
      end
      S_CNT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = pfc_pkg::SEL_CNT;
          ent_nxt  = '0;
          lane_nxt = 2'd0;
          state_nxt = (fcnt_r == '0) ? S_CRC : S_CODE;
        end
      end
      S_CODE: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = pfc_pkg::SEL_CODE;
          lane_nxt  = 2'd0;
          state_nxt = S_VAL;
        end
      end
      S_VAL: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = pfc_pkg::SEL_VAL;
          lane_nxt = lane_r + 2'd1;
          if (lane_r == 2'd3) begin
            if (ent_r == fcnt_r - CW'(1)) begin
              state_nxt = S_CRC;
            end else begin
              ent_nxt   = ent_r + CW'(1);
              state_nxt = S_CODE;
            end
          end
        end
      end
      S_CRC: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.sel       = pfc_pkg::SEL_CRC;
          cmd.frame_end = (lane_r == 2'd3);
          cmd.run_last  = (lane_r == 2'd3) && final_r;
          lane_nxt      = lane_r + 2'd1;
          if (lane_r == 2'd3) begin
            // closing frame after a full one always carries no entries
            if (close_pend_r) begin
              state_nxt      = S_PRE;
              fcnt_nxt       = '0;
              close_pend_nxt = 1'b0;
              final_nxt      = 1'b1;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      lane_r       <= 2'd0;
      ent_r        <= '0;
      fcnt_r       <= '0;
      close_pend_r <= 1'b0;
      final_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      lane_r       <= lane_nxt;
      ent_r        <= ent_nxt;
      fcnt_r       <= fcnt_nxt;
      close_pend_r <= close_pend_nxt;
      final_r      <= final_nxt;
    end
  end

`ifndef SYNTH
  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("byte issued while output register is held");

  a_run_last_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.run_last |-> cmd.frame_end)
    else $error("run_last outside a frame end");

  a_quiet_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !stat.full && !close_req) |=> in_ready)
    else $error("item without output left the controller busy");
`endif

endmodule

// ===== hw/rtl/pfc_dp.sv =====
module pfc_dp #(
  parameter int unsigned ENTRIES_PER_FRAME = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_accept,
  input  logic [pfc_pkg::IDX_W-1:0]    in_param_index,
  input  logic [pfc_pkg::VAL_W-1:0]    in_param_value,
  input  logic                         in_last_param,
  input  logic                         cfg_write,
  input  logic [pfc_pkg::MASK_W-1:0]   cfg_param_mask,
  input  pfc_pkg::dp_cmd_t             cmd,
  input  logic [((ENTRIES_PER_FRAME > 1) ? $clog2(ENTRIES_PER_FRAME) : 1)-1:0] ent_idx,
  output pfc_pkg::dp_stat_t            stat,
  output logic [((ENTRIES_PER_FRAME > 1) ? $clog2(ENTRIES_PER_FRAME) : 1)-1:0] fill_count,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_byte,
  output logic                         out_frame_end,
  output logic                         out_run_last
);

  localparam int unsigned IW = (ENTRIES_PER_FRAME > 1) ? $clog2(ENTRIES_PER_FRAME) : 1;
  localparam int unsigned EW = pfc_pkg::IDX_W + pfc_pkg::VAL_W;

  logic [pfc_pkg::MASK_W-1:0] mask_r;
  logic [pfc_pkg::MASK_W:0]   mask_ext;
  logic [EW-1:0]              store_r [ENTRIES_PER_FRAME];
  logic [IW-1:0]              fill_r, fill_nxt;
  logic                       any_r, any_nxt;
  logic [31:0]                crc_r, crc_nxt;
  logic                       out_valid_r;
  logic [7:0]                 out_byte_r;
  logic                       frame_end_r;
  logic                       run_last_r;
  logic                       hit;
  logic                       full;
  logic                       out_free;
  logic [EW-1:0]              entry;
  logic [31:0]                entry_val;
  logic [7:0]                 byte_mux;

  // index 15 lands on the padding bit and is never taken
  assign mask_ext = {1'b0, mask_r};
  assign hit  = ({1'b0, in_param_index} < 5'(pfc_pkg::PARAM_COUNT)) && mask_ext[in_param_index];
  assign full = hit && (fill_r == IW'(ENTRIES_PER_FRAME - 1));
  assign out_free = !out_valid_r || out_ready;

  assign stat.out_free = out_free;
  assign stat.hit      = hit;
  assign stat.full     = full;
  assign stat.any_sent = any_r;
  assign fill_count    = fill_r;

  assign entry     = store_r[ent_idx];
  assign entry_val = entry[pfc_pkg::VAL_W-1:0];

  always_comb begin
    case (cmd.sel)
      pfc_pkg::SEL_PRE:  byte_mux = pfc_pkg::PREAMBLE_BYTE;
      pfc_pkg::SEL_CNT:  byte_mux = cmd.cnt_byte;
      pfc_pkg::SEL_CODE: byte_mux = 8'(entry[EW-1:pfc_pkg::VAL_W]);
      pfc_pkg::SEL_VAL:  byte_mux = entry_val[8*cmd.lane +: 8];
      pfc_pkg::SEL_CRC:  byte_mux = crc_r[8*cmd.lane +: 8];
      default:           byte_mux = 8'd0;
    endcase
  end

  always_comb begin
    fill_nxt = fill_r;
    any_nxt  = any_r;
    if (in_accept) begin
      if (in_last_param) begin
        fill_nxt = '0;
        any_nxt  = 1'b0;
      end else begin
        if (full) begin
          fill_nxt = '0;
        end else if (hit) begin
          fill_nxt = fill_r + IW'(1);
        end
        if (hit) begin
          any_nxt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    crc_nxt = crc_r;
    if (cmd.emit && (cmd.sel != pfc_pkg::SEL_CRC)) begin
      crc_nxt = pfc_pkg::crc_byte(cmd.crc_clr ? 32'd0 : crc_r, byte_mux);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && hit) begin
      store_r[fill_r] <= {in_param_index, in_param_value};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r  <= byte_mux;
      frame_end_r <= cmd.frame_end;
      run_last_r  <= cmd.run_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      fill_r      <= '0;
      any_r       <= 1'b0;
      crc_r       <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write) begin
        mask_r <= cfg_param_mask;
      end
      fill_r <= fill_nxt;
      any_r  <= any_nxt;
      crc_r  <= crc_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_frame_end = frame_end_r;
  assign out_run_last  = run_last_r;

`ifndef SYNTH
  a_fill_below_frame: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= IW'(ENTRIES_PER_FRAME - 1))
    else $error("fill count reached a full frame without emptying");

  a_fill_implies_any: assert property (@(posedge clk) disable iff (!rst_n)
    !any_r |-> (fill_r == '0))
    else $error("entries held with no entry recorded in the set");

  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_last_param) |=> (!any_r && (fill_r == '0)))
    else $error("closing request left entries behind");
`endif

endmodule

// ===== hw/rtl/parameter_packet_framer_crc32.sv =====
// channel  dir  handshake       payload
// in_chan  in   valid / ready   param_index[3:0], param_value[31:0], last_param
// out_chan out  valid / ready   out_byte[7:0], frame_end, run_last
// cfg_chan in   valid / ready   param_mask[14:0], ready always high
//
// a request that sends nothing leaves the block ready for the next; one that sends
// frames emits 9 + 5 * entries bytes a frame, at one byte a cycle set by the
// single output register when out_chan.ready stays high
// reset is synchronous on rst_n, no clearing pass; the entry store is never read unwritten
// a stalled output holds the controller in place; the next request is taken once it idles
module parameter_packet_framer_crc32 #(
  parameter int unsigned ENTRIES_PER_FRAME = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  pfc_in_if.sink     in_chan,
  pfc_out_if.source  out_chan,
  pfc_cfg_if.sink    cfg_chan
);

  localparam int unsigned IW = (ENTRIES_PER_FRAME > 1) ? $clog2(ENTRIES_PER_FRAME) : 1;

  pfc_pkg::dp_cmd_t  cmd;
  pfc_pkg::dp_stat_t stat;
  logic [IW-1:0]     ent_idx;
  logic [IW-1:0]     fill_count;
  logic              in_ready;
  logic              in_accept;

  assign in_chan.ready  = in_ready;
  assign in_accept      = in_chan.valid && in_ready;
  assign cfg_chan.ready = 1'b1;

  pfc_ctrl #(
    .ENTRIES_PER_FRAME (ENTRIES_PER_FRAME)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_accept     (in_accept),
    .in_last_param (in_chan.last_param),
    .stat          (stat),
    .fill_count    (fill_count),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .ent_idx       (ent_idx)
  );

  pfc_dp #(
    .ENTRIES_PER_FRAME (ENTRIES_PER_FRAME)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_accept      (in_accept),
    .in_param_index (in_chan.param_index),
    .in_param_value (in_chan.param_value),
    .in_last_param  (in_chan.last_param),
    .cfg_write      (cfg_chan.valid),
    .cfg_param_mask (cfg_chan.param_mask),
    .cmd            (cmd),
    .ent_idx        (ent_idx),
    .stat           (stat),
    .fill_count     (fill_count),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_byte       (out_chan.out_byte),
    .out_frame_end  (out_chan.frame_end),
    .out_run_last   (out_chan.run_last)
  );

endmodule

// ===== tb/tb.sv =====
module tb;

  localparam int unsigned FRAME_ENTRIES = 6;
  localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
  localparam logic [7:0]  SYNC_BYTE     = 8'hAA;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned N_ROWS        = 23;

  typedef enum logic [2:0] {
    PACE_FULL,
    PACE_SRC_GAPS,
    PACE_SINK_STALL,
    PACE_BOTH,
    PACE_HOLD
  } pace_t;

  typedef struct packed {
    logic [7:0] data;
    logic       frame_end;
    logic       run_last;
  } out_beat_t;

  typedef struct packed {
    logic [pfc_pkg::IDX_W-1:0] index;
    logic [pfc_pkg::VAL_W-1:0] value;
  } slot_entry_t;

  // new_mask: write mask before the row; silent: no bytes may follow the row
  typedef struct packed {
    logic                       new_mask;
    logic [pfc_pkg::MASK_W-1:0] mask;
    logic [pfc_pkg::IDX_W-1:0]  index;
    logic [pfc_pkg::VAL_W-1:0]  value;
    logic                       last;
    logic                       silent;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  always #10 clk = ~clk;

  pfc_in_if  in_chan ();
  pfc_out_if out_chan ();
  pfc_cfg_if cfg_chan ();

  parameter_packet_framer_crc32 #(
    .ENTRIES_PER_FRAME(FRAME_ENTRIES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // framer model state
  slot_entry_t                held_entries [FRAME_ENTRIES];
  int unsigned                held_count;
  logic                       set_has_entry;
  logic [31:0]                frame_crc;
  logic [pfc_pkg::MASK_W-1:0] mask_q;

  out_beat_t   new_bytes [$];
  out_beat_t   expected_bytes [$];
  pace_t       pace;
  int unsigned errors;
  int unsigned slots_taken;
  int unsigned bytes_checked;
  int unsigned frames_seen;
  int unsigned mask_writes;
  int unsigned stall_count;

  dir_row_t directed_rows [N_ROWS] = '{
    '{1'b0, 15'h0000, 4'd0,  32'h00000000, 1'b0, 1'b1},  // reset mask drops the slot
    '{1'b0, 15'h0000, 4'd14, 32'hFFFFFFFF, 1'b1, 1'b1},  // close with nothing taken
    '{1'b1, 15'h7FFF, 4'd15, 32'h12345678, 1'b1, 1'b1},  // index out of range
    '{1'b0, 15'h7FFF, 4'd0,  32'h00000000, 1'b1, 1'b0},
    '{1'b0, 15'h7FFF, 4'd14, 32'hFFFFFFFF, 1'b0, 1'b0},
    '{1'b0, 15'h7FFF, 4'd14, 32'h80000001, 1'b0, 1'b0},  // repeated index
    '{1'b0, 15'h7FFF, 4'd15, 32'hA5A5A5A5, 1'b0, 1'b1},
    '{1'b0, 15'h7FFF, 4'd3,  32'h00000001, 1'b0, 1'b0},
    '{1'b0, 15'h7FFF, 4'd7,  32'h7FFFFFFF, 1'b0, 1'b0},
    '{1'b0, 15'h7FFF, 4'd1,  32'h5A5AC3C3, 1'b0, 1'b0},
    '{1'b0, 15'h7FFF, 4'd2,  32'hDEADBEEF, 1'b0, 1'b0},
    '{1'b0, 15'h7FFF, 4'd5,  32'h00FF00FF, 1'b1, 1'b0},
    '{1'b0, 15'h7FFF, 4'd8,  32'h01234567, 1'b0, 1'b0},
    '{1'b0, 15'h7FFF, 4'd9,  32'h89ABCDEF, 1'b0, 1'b0},
    '{1'b0, 15'h7FFF, 4'd10, 32'hFEDCBA98, 1'b0, 1'b0},
    '{1'b0, 15'h7FFF, 4'd11, 32'h76543210, 1'b0, 1'b0},
    '{1'b0, 15'h7FFF, 4'd12, 32'hC0FFEE00, 1'b0, 1'b0},
    '{1'b0, 15'h7FFF, 4'd13, 32'h0000FFFF, 1'b1, 1'b0},  // full frame then empty close
    '{1'b1, 15'h4001, 4'd1,  32'h11111111, 1'b0, 1'b1},  // masked out
    '{1'b0, 15'h4001, 4'd0,  32'hFFFFFFFF, 1'b1, 1'b0},
    '{1'b0, 15'h4001, 4'd13, 32'h22222222, 1'b1, 1'b1},
    '{1'b0, 15'h4001, 4'd14, 32'h00000000, 1'b0, 1'b0},
    '{1'b0, 15'h4001, 4'd15, 32'h33333333, 1'b1, 1'b0}   // out of range slot closes set
  };

  function automatic logic [31:0] crc_reflected(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++)
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic void put_crc_byte(input logic [7:0] b);
    frame_crc = crc_reflected(frame_crc, b);
    new_bytes.push_back('{b, 1'b0, 1'b0});
  endfunction

  function automatic void build_frame(input int unsigned count);
    frame_crc = 32'd0;
    repeat (4) put_crc_byte(SYNC_BYTE);
    put_crc_byte(8'(count));
    for (int i = 0; i < count; i++) begin
      put_crc_byte({4'd0, held_entries[i].index});
      for (int k = 0; k < 4; k++)
        put_crc_byte(held_entries[i].value[8*k +: 8]);
    end
    for (int k = 0; k < 4; k++)
      new_bytes.push_back('{frame_crc[8*k +: 8], k == 3, 1'b0});
  endfunction

  // bytes that one accepted slot causes, left in new_bytes
  function automatic void framer_step(input logic [pfc_pkg::IDX_W-1:0] index,
                                      input logic [pfc_pkg::VAL_W-1:0] value,
                                      input logic last);
    new_bytes.delete();
    if (index < pfc_pkg::PARAM_COUNT && mask_q[index]) begin
      held_entries[held_count] = '{index, value};
      held_count++;
      set_has_entry = 1'b1;
      if (held_count == FRAME_ENTRIES) begin
        build_frame(FRAME_ENTRIES);
        held_count = 0;
      end
    end
    if (last) begin
      if (set_has_entry)
        build_frame(held_count);
      held_count    = 0;
      set_has_entry = 1'b0;
    end
    if (new_bytes.size() != 0)
      new_bytes[$].run_last = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= 30)
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
  endtask

  task automatic send_slot(input logic [pfc_pkg::IDX_W-1:0] index,
                           input logic [pfc_pkg::VAL_W-1:0] value,
                           input logic last, input logic silent);
    @(negedge clk);
    while ((pace == PACE_SRC_GAPS && $urandom_range(99) < 68) ||
           (pace == PACE_BOTH && $urandom_range(99) < 32)) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid       = 1'b1;
    in_chan.param_index = index;
    in_chan.param_value = value;
    in_chan.last_param  = last;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    slots_taken++;
    framer_step(index, value, last);
    if (silent && new_bytes.size() != 0)
      report_mismatch("bytes after a silent row", 32'(new_bytes.size()), 32'd0);
    else
      foreach (new_bytes[i]) expected_bytes.push_back(new_bytes[i]);
  endtask

  task automatic drain();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    // a request that sends nothing may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mask(input logic [pfc_pkg::MASK_W-1:0] mask);
    drain();
    @(negedge clk);
    cfg_chan.valid      = 1'b1;
    cfg_chan.param_mask = mask;
    do @(posedge clk); while (cfg_chan.ready !== 1'b1);
    mask_q = mask;
    mask_writes++;
    @(negedge clk);
    cfg_chan.valid = 1'b0;
  endtask

  task automatic random_phase(input logic [pfc_pkg::MASK_W-1:0] mask, input pace_t mode,
                              input int unsigned n_slots);
    logic [pfc_pkg::IDX_W-1:0] index;
    logic [pfc_pkg::VAL_W-1:0] value;
    logic                      last;
    int unsigned               next_slot;
    next_slot = 0;
    write_mask(mask);
    pace = mode;
    repeat (n_slots) begin
      if ($urandom_range(99) < 80) begin
        // ordered sweep of the whole set
        index     = pfc_pkg::IDX_W'(next_slot);
        last      = (next_slot == pfc_pkg::PARAM_COUNT - 1);
        next_slot = last ? 0 : next_slot + 1;
      end else begin
        index = pfc_pkg::IDX_W'($urandom_range(15));
        last  = ($urandom_range(5) == 0);
      end
      case ($urandom_range(7))
        0:       value = 32'h00000000;
        1:       value = 32'hFFFFFFFF;
        default: value = $urandom;
      endcase
      send_slot(index, value, last, 1'b0);
    end
  endtask

  // result side: pacing and hold-off
  initial begin
    int unsigned held_for;
    held_for = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (pace != PACE_HOLD)
        held_for = 0;
      case (pace)
        PACE_SINK_STALL: out_chan.ready = ($urandom_range(99) >= 68);
        PACE_BOTH:       out_chan.ready = ($urandom_range(99) >= 32);
        PACE_HOLD: begin
          if (held_for < HOLD_CYCLES) begin
            out_chan.ready = 1'b0;
            held_for++;
          end else begin
            out_chan.ready = ($urandom_range(3) != 0);
          end
        end
        default:         out_chan.ready = 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      bytes_checked++;
      if (out_chan.frame_end === 1'b1)
        frames_seen++;
      if (expected_bytes.size() == 0) begin
        report_mismatch("byte with nothing expected", 32'(out_chan.out_byte), 32'd0);
      end else begin
        want = expected_bytes.pop_front();
        if (out_chan.out_byte !== want.data)
          report_mismatch("out_byte", 32'(out_chan.out_byte), 32'(want.data));
        if (out_chan.frame_end !== want.frame_end)
          report_mismatch("frame_end", 32'(out_chan.frame_end), 32'(want.frame_end));
        if (out_chan.run_last !== want.run_last)
          report_mismatch("run_last", 32'(out_chan.run_last), 32'(want.run_last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
        (out_chan.valid === 1'b1 && out_chan.ready === 1'b1) ||
        (cfg_chan.valid === 1'b1 && cfg_chan.ready === 1'b1))
      stall_count = 0;
    else
      stall_count++;
    if (stall_count == STALL_LIMIT) begin
      $display("no request moved for %0d cycles, %0d bytes still due",
               STALL_LIMIT, expected_bytes.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    errors        = 0;
    slots_taken   = 0;
    bytes_checked = 0;
    frames_seen   = 0;
    mask_writes   = 0;
    stall_count   = 0;
    held_count    = 0;
    set_has_entry = 1'b0;
    frame_crc     = 32'd0;
    mask_q        = '0;
    pace          = PACE_FULL;
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.param_index = '0;
    in_chan.param_value = '0;
    in_chan.last_param  = 1'b0;
    cfg_chan.valid      = 1'b0;
    cfg_chan.param_mask = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    pace = PACE_SINK_STALL;
    foreach (directed_rows[r]) begin
      if (directed_rows[r].new_mask)
        write_mask(directed_rows[r].mask);
      send_slot(directed_rows[r].index, directed_rows[r].value,
                directed_rows[r].last, directed_rows[r].silent);
    end

    random_phase(15'h7FFF, PACE_FULL, 50);
    random_phase(pfc_pkg::MASK_W'($urandom_range(32767)), PACE_SRC_GAPS, 50);
    // twelve indexes per set, so a full ordered sweep closes with an empty frame
    random_phase(15'h0FFF, PACE_SINK_STALL, 50);
    random_phase(pfc_pkg::MASK_W'($urandom_range(32767)), PACE_BOTH, 50);
    random_phase(15'h7FFF, PACE_HOLD, 50);
    random_phase(15'h0000, PACE_FULL, 10);
    random_phase(15'h4000, PACE_BOTH, 30);

    drain();
    if (expected_bytes.size() != 0)
      report_mismatch("bytes never sent", 32'(expected_bytes.size()), 32'd0);
    $display("run covered %0d parameter slots over %0d mask settings and five pacing modes",
             slots_taken, mask_writes);
    $display("%0d framed bytes in %0d frames compared, %0d mismatches",
             bytes_checked, frames_seen, errors);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
